@@ rtl/core/knmh_pkg.sv @@
package knmh_pkg;
  localparam int CAPACITY_DEF = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int ID_BITS_DEF = 16;
  localparam int DIST_BITS = 33;
  localparam int KW_BITS = 7;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_OFFER = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_QX = 2'd0,
    REG_QY = 2'd1,
    REG_RAD = 2'd2,
    REG_KW = 2'd3
  } reg_t;
endpackage

@@ rtl/core/knmh_ram.sv @@
module knmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/knmh_dist.sv @@
module knmh_dist
  import knmh_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic signed [COORD_BITS-1:0] qx,
  input  logic signed [COORD_BITS-1:0] qy,
  output logic [DIST_BITS-1:0]         dsq
);
  // two stages: difference, then square and saturating add
  localparam int DW = COORD_BITS + 1;
  localparam int SW = 2 * COORD_BITS + 1;
  logic [COORD_BITS-1:0] ax, ay;
  logic signed [DW-1:0] dx, dy;
  logic [2*COORD_BITS-1:0] px, py;
  logic [SW-1:0] sum;

  always_comb begin
    dx = DW'(cx) - DW'(qx);
    dy = DW'(cy) - DW'(qy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= dx[DW-1] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
      ay <= dy[DW-1] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    end
  end

  always_comb begin
    px = (2*COORD_BITS)'(ax) * (2*COORD_BITS)'(ax);
    py = (2*COORD_BITS)'(ay) * (2*COORD_BITS)'(ay);
    sum = SW'(px) + SW'(py);
  end

  always_ff @(posedge clk) begin
    if (SW > DIST_BITS) begin
      if (|(sum >> DIST_BITS)) dsq <= DIST_MAX;
      else dsq <= DIST_BITS'(sum);
    end else begin
      dsq <= DIST_BITS'(sum);
    end
  end
endmodule

@@ rtl/core/k_nearest_max_heap_select.sv @@
// k-nearest selector with a bounded max-heap in two single-port-read rams
// (distance and id). mode 0 clears, mode 1 offers a candidate, mode 2 reads
// out every held entry in store order. a clear or an unused mode is done at
// acceptance. an offer that is dropped or appended passes accept, two distance
// stages and decide. a replacement sift-down visits heap nodes, each with the
// steps read both children, compare and write. the first overflow runs a
// heapify before that: each internal node is read and then sifted, and a final
// node step finishes it. a read-out takes a read and an output step per result,
// or a single output step when nothing is held, plus any output stall. one
// request is worked on at a time; input stall is high while busy.
module k_nearest_max_heap_select
  import knmh_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   mode,
  input  logic signed [COORD_BITS-1:0] cand_x,
  input  logic signed [COORD_BITS-1:0] cand_y,
  input  logic [ID_BITS-1:0]           cand_id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  entry_id,
  output logic [DIST_BITS-1:0]         entry_dist_sq,
  output logic [KW_BITS-1:0]           found_count,
  output logic [DIST_BITS-1:0]         bound_sq,
  output logic                         empty_res,
  output logic                         last
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NW = AW + 1;

  logic signed [COORD_BITS-1:0] query_x, query_y;
  logic [DIST_BITS-1:0] radius_sq;
  logic [KW_BITS-1:0] k_wanted;

  // config port
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      query_x <= '0;
      query_y <= '0;
      radius_sq <= DIST_MAX;
      k_wanted <= KW_BITS'(16);
    end else if (cfg_we) begin
      case (reg_t'(paddr[3+:2]))
        REG_QX: if (paddr[2:0] == 3'd0) query_x <= COORD_BITS'(pwdata[15:0]);
        REG_QY: if (paddr[2:0] == 3'd0) query_y <= COORD_BITS'(pwdata[15:0]);
        REG_RAD: if (paddr[2:0] == 3'd0) radius_sq <= pwdata[DIST_BITS-1:0];
        REG_KW: if (paddr[2:0] == 3'd0) k_wanted <= pwdata[KW_BITS-1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      case (reg_t'(paddr[3+:2]))
        REG_QX: prdata = 64'(unsigned'(16'(query_x)));
        REG_QY: prdata = 64'(unsigned'(16'(query_y)));
        REG_RAD: prdata = 64'(radius_sq);
        REG_KW: prdata = 64'(k_wanted);
        default: prdata = '0;
      endcase
    end
  end

  // memories
  logic d_we;
  logic [AW-1:0] d_waddr, d_raddr;
  logic [DIST_BITS-1:0] d_wdata, d_rdata;
  logic [ID_BITS-1:0] i_wdata, i_rdata;

  knmh_ram #(.WIDTH(DIST_BITS), .DEPTH(CAPACITY)) u_dram (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr), .rdata(d_rdata)
  );
  knmh_ram #(.WIDTH(ID_BITS), .DEPTH(CAPACITY)) u_iram (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(i_wdata), .raddr(d_raddr), .rdata(i_rdata)
  );

  logic [COORD_BITS-1:0] cx, cy;
  logic [ID_BITS-1:0] cid;
  logic [DIST_BITS-1:0] cand_d;
  logic dist_en;
  knmh_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk, .en(dist_en), .cx(cx), .cy(cy), .qx(query_x), .qy(query_y), .dsq(cand_d)
  );

  typedef enum logic [3:0] {
    S_IDLE, S_D1, S_D2, S_DEC, S_HNODE, S_HRD, S_SRD1, S_SRD2, S_SCMP, S_READ, S_OUT
  } state_t;

  state_t state;
  logic [NW-1:0] held_count;
  logic heap_built;
  logic [DIST_BITS-1:0] accept_bound;
  logic [NW-1:0] hi;        // heapify counter (node index + 1)
  logic heapify;            // current sift is part of heapify
  logic [NW-1:0] p;         // sift position
  logic [DIST_BITS-1:0] sd, cd1;
  logic [ID_BITS-1:0] sid, cid1;
  logic [NW-1:0] rd_i;
  logic [NW-1:0] k_eff;
  logic [NW-1:0] lc;
  logic take_right, descend;
  logic [DIST_BITS-1:0] best_d;
  logic [ID_BITS-1:0] best_i;
  logic [DIST_BITS-1:0] root_d;

  assign dist_en = (state == S_D1);
  assign in_stall = (state != S_IDLE);
  assign lc = NW'(2 * p + 1);

  always_comb begin
    if (k_wanted == '0) k_eff = NW'(1);
    else if (32'(k_wanted) > CAPACITY) k_eff = NW'(CAPACITY);
    else k_eff = NW'(k_wanted);
  end

  // larger child, and whether the sifted entry moves below it
  always_comb begin
    take_right = (lc + NW'(1) < held_count) && (cd1 < d_rdata);
    best_d = take_right ? d_rdata : cd1;
    best_i = take_right ? i_rdata : cid1;
    descend = (lc < held_count) && !(heapify ? (sd >= best_d) : (sd > best_d));
  end

  // ram port steering
  always_comb begin
    d_we = 1'b0;
    d_waddr = '0;
    d_wdata = sd;
    i_wdata = sid;
    d_raddr = '0;
    case (state)
      S_DEC: begin
        d_waddr = AW'(held_count);
        d_wdata = cand_d;
        i_wdata = cid;
        d_we = (cand_d <= accept_bound) && (held_count < k_eff);
      end
      S_HNODE: d_raddr = AW'(hi - NW'(1));
      S_SRD1: d_raddr = AW'(lc);
      S_SRD2: d_raddr = AW'(lc + NW'(1));
      S_SCMP: begin
        d_waddr = AW'(p);
        d_we = 1'b1;
        // write the promoted child, else final entry
        if (descend) begin
          d_wdata = best_d;
          i_wdata = best_i;
        end
      end
      S_READ: d_raddr = AW'(rd_i);
      default: ;
    endcase
  end

  logic out_fire;
  assign out_fire = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      held_count <= '0;
      heap_built <= 1'b0;
      accept_bound <= DIST_MAX;
      out_valid <= 1'b0;
      heapify <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cx <= cand_x;
            cy <= cand_y;
            cid <= cand_id;
            case (mode_t'(mode))
              MODE_CLEAR: begin
                held_count <= '0;
                heap_built <= 1'b0;
                accept_bound <= radius_sq;
              end
              MODE_OFFER: state <= S_D1;
              MODE_READ: begin
                rd_i <= '0;
                if (held_count == '0) begin
                  entry_id <= '0;
                  entry_dist_sq <= '0;
                  found_count <= '0;
                  bound_sq <= accept_bound;
                  empty_res <= 1'b1;
                  last <= 1'b1;
                  out_valid <= 1'b1;
                  state <= S_OUT;
                end else begin
                  state <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end
        S_D1: state <= S_D2;
        S_D2: state <= S_DEC;
        S_DEC: begin
          if (cand_d > accept_bound) begin
            state <= S_IDLE;
          end else if (held_count < k_eff) begin
            held_count <= held_count + NW'(1);
            state <= S_IDLE;
          end else if (!heap_built) begin
            hi <= held_count >> 1;
            heapify <= 1'b1;
            state <= S_HNODE;
          end else begin
            heapify <= 1'b0;
            p <= '0;
            sd <= cand_d;
            sid <= cid;
            state <= S_SRD1;
          end
        end
        S_HNODE: begin
          if (hi == '0) begin
            heap_built <= 1'b1;
            heapify <= 1'b0;
            p <= '0;
            sd <= cand_d;
            sid <= cid;
            state <= S_SRD1;
          end else begin
            p <= hi - NW'(1);
            state <= S_HRD;
          end
        end
        S_HRD: begin
          sd <= d_rdata;
          sid <= i_rdata;
          state <= S_SRD1;
        end
        S_SRD1: state <= S_SRD2;
        S_SRD2: begin
          cd1 <= d_rdata;
          cid1 <= i_rdata;
          state <= S_SCMP;
        end
        S_SCMP: begin
          if (descend) begin
            p <= take_right ? lc + NW'(1) : lc;
            state <= S_SRD1;
          end else if (heapify) begin
            hi <= hi - NW'(1);
            state <= S_HNODE;
          end else begin
            state <= S_IDLE;
            // bound follows the root, written in the first step of the sift
            accept_bound <= (p == '0) ? sd : root_d;
          end
        end
        S_READ: begin
          if (!out_valid || out_fire) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            entry_id <= 16'(i_rdata);
            entry_dist_sq <= d_rdata;
            found_count <= KW_BITS'(held_count);
            bound_sq <= accept_bound;
            empty_res <= 1'b0;
            last <= (rd_i + NW'(1) == held_count);
            out_valid <= 1'b1;
            rd_i <= rd_i + NW'(1);
          end else if (out_fire) begin
            out_valid <= 1'b0;
            if (last) state <= S_IDLE;
            else state <= S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCMP && d_waddr == '0) root_d <= d_wdata;
  end

  a_no_out_when_busy_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("result while idle");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= NW'(CAPACITY)) else $error("held count over capacity");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(entry_dist_sq))
    else $error("stalled result changed");
endmodule
